[rtl/jpeg_marker_header_checker_defines.svh]
// ----------------------------------------------------------------------------
// jpeg marker header checker assertion macros
// shared property forms for the checker rtl, clocked on i_clk, off in reset
// ----------------------------------------------------------------------------
`ifndef JPEG_MARKER_HEADER_CHECKER_DEFINES_SVH
`define JPEG_MARKER_HEADER_CHECKER_DEFINES_SVH

// same-cycle implication
`define JMHC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("jmhc assertion failed");

// next-cycle implication
`define JMHC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("jmhc assertion failed");

`endif

[rtl/jmhc_pkg.sv]
// ----------------------------------------------------------------------------
// jmhc_pkg
// constants, types and marker classification for the jpeg marker header checker
// ----------------------------------------------------------------------------
package jmhc_pkg;

    localparam int FRAME_LEN_BITS_DEF = 24;

    // configuration register indexes
    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] CFG_EXPECTED_WIDTH  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_EXPECTED_HEIGHT = 1'b1;

    // marker codes
    localparam logic [7:0] MRK_PREFIX = 8'hff;
    localparam logic [7:0] MRK_SOI    = 8'hd8;
    localparam logic [7:0] MRK_EOI    = 8'hd9;
    localparam logic [7:0] MRK_SOS    = 8'hda;
    localparam logic [7:0] MRK_TEM    = 8'h01;
    localparam logic [7:0] MRK_ZERO   = 8'h00;
    localparam logic [7:0] MRK_RST_LO = 8'hd0;
    localparam logic [7:0] MRK_RST_HI = 8'hd7;

    localparam int MIN_FRAME_LEN = 16;
    localparam logic [15:0] MIN_SEG_LEN = 16'd2;
    localparam logic [15:0] MIN_SOF_LEN = 16'd7;

    typedef enum logic [6:0] {
        PH_SOI    = 7'b0000001,
        PH_PREFIX = 7'b0000010,
        PH_FILL   = 7'b0000100,
        PH_LEN_HI = 7'b0001000,
        PH_LEN_LO = 7'b0010000,
        PH_BODY   = 7'b0100000,
        PH_DONE   = 7'b1000000
    } t_phase;

    // start of frame codes: c0-c3, c5-c7, c9-cb, cd-cf
    function automatic logic is_sof(input logic [7:0] m);
        return (m[7:4] == 4'hc) && (m[1:0] != 2'b00 || m[3:2] == 2'b00);
    endfunction

    function automatic logic is_rejected(input logic [7:0] m);
        return (m == MRK_ZERO) || (m == MRK_TEM) || (m == MRK_SOI) ||
               (m == MRK_EOI) || (m >= MRK_RST_LO && m <= MRK_RST_HI);
    endfunction

endpackage

[rtl/jpeg_marker_header_checker.sv]
// path: a frame's result is formed from its last byte in the input register and held in the result register
// throughput: one byte per cycle; both stages hold while the result register is full
// and not taken, the input register decouples the input side by one transaction
// reset: i_rst_n is synchronous and active low, clears the frame walk, the expected
// dimensions and both valid flags
// ----------------------------------------------------------------------------
// jpeg marker header checker
// walks the marker segments of one motion-jpeg frame and reports its header status
// ----------------------------------------------------------------------------
`include "jpeg_marker_header_checker_defines.svh"

module jpeg_marker_header_checker #(
    parameter int FRAME_LEN_BITS = jmhc_pkg::FRAME_LEN_BITS_DEF,
    localparam int IN_W  = ((8 + FRAME_LEN_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((49 + 2 * FRAME_LEN_BITS + 7) / 8) * 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [jmhc_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [15:0]                     i_cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // data_byte, frame_length
    input  logic [IN_W-1:0]                 s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // frame_valid, width, height, sof_type, entropy_start, error_offset, error_marker
    output logic [OUT_W-1:0]                m_axis_tdata
);
    import jmhc_pkg::*;

    localparam int LW = FRAME_LEN_BITS;

    logic [15:0]   r_exp_width;
    logic [15:0]   r_exp_height;

    logic          r_in_valid;
    logic [7:0]    r_in_byte;
    logic [LW-1:0] r_in_len;

    logic          r_out_valid;
    logic [OUT_W-1:0] r_out_data;
    logic [OUT_W-1:0] n_out_data;

    logic [LW-1:0] r_byte_index,   n_byte_index;
    t_phase        r_phase,        n_phase;
    logic [15:0]   r_seg_rem,      n_seg_rem;
    logic [15:0]   r_seg_len,      n_seg_len;
    logic [LW-1:0] r_marker_start, n_marker_start;
    logic [7:0]    r_cur_marker,   n_cur_marker;
    logic          r_seen_sof,     n_seen_sof;
    logic          r_seen_sos,     n_seen_sos;
    logic [15:0]   r_frame_width,  n_frame_width;
    logic [15:0]   r_frame_height, n_frame_height;
    logic [7:0]    r_last_sof,     n_last_sof;
    logic [LW-1:0] r_scan_start,   n_scan_start;
    logic          r_hdr_failed,   n_hdr_failed;
    logic [LW-1:0] r_fail_offset,  n_fail_offset;
    logic [7:0]    r_fail_marker,  n_fail_marker;
    logic          r_head_ok,      n_head_ok;
    logic [7:0]    r_prev_byte;

    logic adv;
    logic in_acc;
    logic last;

    assign adv           = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // marker walk and result formation for the byte in the input register
    always_comb begin
        logic [7:0]    b;
        logic [15:0]   seg;
        logic [15:0]   k;
        logic [LW:0]   seg_end;
        logic          fault;
        logic [LW-1:0] f_off;
        logic [7:0]    f_mrk;
        logic          seg_done;
        logic          tail_bad;
        logic          dim_bad;
        logic          res_valid;
        logic [15:0]   res_w;
        logic [15:0]   res_h;
        logic [7:0]    res_sof;
        logic [LW-1:0] res_scan;
        logic [LW-1:0] res_eoff;
        logic [7:0]    res_emrk;

        b        = r_in_byte;
        seg      = {r_seg_len[15:8], b};
        k        = (r_seg_len - MIN_SEG_LEN) - r_seg_rem;
        seg_end  = {1'b0, r_byte_index} + (LW+1)'(seg) + (LW+1)'(1);
        fault    = 1'b0;
        f_off    = r_byte_index;
        f_mrk    = b;
        seg_done = 1'b0;

        n_phase        = r_phase;
        n_seg_rem      = r_seg_rem;
        n_seg_len      = r_seg_len;
        n_marker_start = r_marker_start;
        n_cur_marker   = r_cur_marker;
        n_seen_sof     = r_seen_sof;
        n_seen_sos     = r_seen_sos;
        n_frame_width  = r_frame_width;
        n_frame_height = r_frame_height;
        n_last_sof     = r_last_sof;
        n_scan_start   = r_scan_start;
        n_hdr_failed   = r_hdr_failed;
        n_fail_offset  = r_fail_offset;
        n_fail_marker  = r_fail_marker;
        n_head_ok      = r_head_ok;

        unique case (r_phase)
            PH_SOI: begin
                if (r_byte_index == '0) begin
                    n_head_ok = (b == MRK_PREFIX);
                end else begin
                    n_head_ok = r_head_ok && (b == MRK_SOI);
                    n_phase   = PH_PREFIX;
                end
            end
            PH_PREFIX: begin
                if (b != MRK_PREFIX) begin
                    fault = 1'b1;
                end else begin
                    n_marker_start = r_byte_index;
                    n_phase        = PH_FILL;
                end
            end
            PH_FILL: begin
                // fill bytes keep the walk here
                if (b != MRK_PREFIX) begin
                    if (is_rejected(b)) begin
                        fault = 1'b1;
                        f_off = r_marker_start;
                    end else begin
                        n_cur_marker = b;
                        n_phase      = PH_LEN_HI;
                    end
                end
            end
            PH_LEN_HI: begin
                n_seg_len = {b, 8'h00};
                n_phase   = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_seg_len = seg;
                // segment may not reach the two trailing bytes
                if (seg < MIN_SEG_LEN || seg_end > {1'b0, r_in_len} ||
                    (is_sof(r_cur_marker) && (seg < MIN_SOF_LEN || r_seen_sof))) begin
                    fault = 1'b1;
                    f_off = r_marker_start;
                    f_mrk = r_cur_marker;
                end else begin
                    if (is_sof(r_cur_marker)) begin
                        n_last_sof = r_cur_marker;
                    end
                    n_seg_rem = seg - MIN_SEG_LEN;
                    if (seg == MIN_SEG_LEN) begin
                        seg_done = 1'b1;
                    end else begin
                        n_phase = PH_BODY;
                    end
                end
            end
            PH_BODY: begin
                if (is_sof(r_cur_marker)) begin
                    if (k == 16'd1) begin
                        n_frame_height = {b, 8'h00};
                    end else if (k == 16'd2) begin
                        n_frame_height = {r_frame_height[15:8], b};
                    end else if (k == 16'd3) begin
                        n_frame_width = {b, 8'h00};
                    end else if (k == 16'd4) begin
                        n_frame_width = {r_frame_width[15:8], b};
                        n_seen_sof    = (n_frame_width != '0) && (r_frame_height != '0);
                    end
                end
                n_seg_rem = r_seg_rem - 16'd1;
                if (r_seg_rem == 16'd1) begin
                    seg_done = 1'b1;
                end
            end
            PH_DONE: begin
            end
            default: begin
            end
        endcase

        if (seg_done) begin
            if (r_cur_marker == MRK_SOS) begin
                n_seen_sos   = 1'b1;
                n_scan_start = r_byte_index + LW'(1);
                n_phase      = PH_DONE;
            end else begin
                n_phase = PH_PREFIX;
            end
        end

        if (fault) begin
            n_hdr_failed  = 1'b1;
            n_fail_offset = f_off;
            n_fail_marker = f_mrk;
            n_phase       = PH_DONE;
        end

        last = ({1'b0, r_byte_index} + (LW+1)'(1)) >= {1'b0, r_in_len};

        tail_bad = (r_in_len < LW'(MIN_FRAME_LEN)) || !n_head_ok ||
                   (r_prev_byte != MRK_PREFIX) || (b != MRK_EOI);
        dim_bad  = !n_seen_sof || !n_seen_sos ||
                   (r_exp_width != '0 && n_frame_width != r_exp_width) ||
                   (r_exp_height != '0 && n_frame_height != r_exp_height);

        res_valid = 1'b0;
        res_w     = '0;
        res_h     = '0;
        res_sof   = '0;
        res_scan  = '0;
        res_eoff  = '0;
        res_emrk  = '0;
        if (!tail_bad) begin
            res_sof  = n_last_sof;
            res_scan = n_scan_start;
            priority if (n_hdr_failed) begin
                res_eoff = n_fail_offset;
                res_emrk = n_fail_marker;
            end else if (dim_bad) begin
                res_eoff = n_scan_start;
            end else begin
                res_valid = 1'b1;
                res_w     = n_frame_width;
                res_h     = n_frame_height;
                res_eoff  = '1;
            end
        end

        n_out_data = OUT_W'({res_emrk, res_eoff, res_scan, res_sof, res_h, res_w, res_valid});

        n_byte_index = r_byte_index + LW'(1);
        if (last) begin
            n_byte_index   = '0;
            n_phase        = PH_SOI;
            n_seg_rem      = '0;
            n_seg_len      = '0;
            n_marker_start = '0;
            n_cur_marker   = '0;
            n_seen_sof     = 1'b0;
            n_seen_sos     = 1'b0;
            n_frame_width  = '0;
            n_frame_height = '0;
            n_last_sof     = '0;
            n_scan_start   = '0;
            n_hdr_failed   = 1'b0;
            n_fail_offset  = '0;
            n_fail_marker  = '0;
            n_head_ok      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_width    <= '0;
            r_exp_height   <= '0;
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_byte_index   <= '0;
            r_phase        <= PH_SOI;
            r_seg_rem      <= '0;
            r_seg_len      <= '0;
            r_marker_start <= '0;
            r_cur_marker   <= '0;
            r_seen_sof     <= 1'b0;
            r_seen_sos     <= 1'b0;
            r_frame_width  <= '0;
            r_frame_height <= '0;
            r_last_sof     <= '0;
            r_scan_start   <= '0;
            r_hdr_failed   <= 1'b0;
            r_fail_offset  <= '0;
            r_fail_marker  <= '0;
            r_head_ok      <= 1'b0;
            r_prev_byte    <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_EXPECTED_WIDTH:  r_exp_width  <= i_cfg_data;
                    CFG_EXPECTED_HEIGHT: r_exp_height <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end

            if (adv) begin
                r_out_valid <= r_in_valid && last;
            end

            if (r_in_valid && adv) begin
                r_byte_index   <= n_byte_index;
                r_phase        <= n_phase;
                r_seg_rem      <= n_seg_rem;
                r_seg_len      <= n_seg_len;
                r_marker_start <= n_marker_start;
                r_cur_marker   <= n_cur_marker;
                r_seen_sof     <= n_seen_sof;
                r_seen_sos     <= n_seen_sos;
                r_frame_width  <= n_frame_width;
                r_frame_height <= n_frame_height;
                r_last_sof     <= n_last_sof;
                r_scan_start   <= n_scan_start;
                r_hdr_failed   <= n_hdr_failed;
                r_fail_offset  <= n_fail_offset;
                r_fail_marker  <= n_fail_marker;
                r_head_ok      <= n_head_ok;
                r_prev_byte    <= last ? 8'h00 : r_in_byte;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_byte <= s_axis_tdata[7:0];
            r_in_len  <= s_axis_tdata[8 +: LW];
        end
        if (r_in_valid && adv && last) begin
            r_out_data <= n_out_data;
        end
    end

    `JMHC_ASSERT_IMP(a_pass_fields, r_out_valid && r_out_data[0],
        r_out_data[1 +: 16] != '0 && r_out_data[17 +: 16] != '0 &&
        r_out_data[41 + LW +: LW] == '1)
    `JMHC_ASSERT_IMP(a_fail_no_dims, r_out_valid && !r_out_data[0],
        r_out_data[1 +: 32] == '0)
    `JMHC_ASSERT_IMP(a_sos_stops_walk, r_seen_sos || r_hdr_failed, r_phase == PH_DONE)
    `JMHC_ASSERT_IMP(a_stall_blocks_input, r_in_valid && r_out_valid && !m_axis_tready,
        !s_axis_tready)
    `JMHC_ASSERT_NXT(a_frame_end_clears, r_in_valid && adv && last,
        r_byte_index == '0 && r_phase == PH_SOI && r_out_valid)

endmodule
